@@ hdl/vcr_pkg.sv @@
// Shared types, codes and reset values for the velocity command ramp.
`timescale 1ns / 1ps

package vcr_pkg;

	// Command codes
	localparam logic [2:0] ACT_HOLD     = 3'd0;
	localparam logic [2:0] ACT_LIN_UP   = 3'd1;
	localparam logic [2:0] ACT_LIN_DOWN = 3'd2;
	localparam logic [2:0] ACT_ANG_UP   = 3'd3;
	localparam logic [2:0] ACT_ANG_DOWN = 3'd4;
	localparam logic [2:0] ACT_STOP     = 3'd5;
	localparam logic [2:0] ACT_QUIT     = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] CFG_LIN_STEP  = 3'd0;
	localparam logic [2:0] CFG_ANG_STEP  = 3'd1;
	localparam logic [2:0] CFG_LIN_LIMIT = 3'd2;
	localparam logic [2:0] CFG_ANG_LIMIT = 3'd3;
	localparam logic [2:0] CFG_LIN_SLEW  = 3'd4;
	localparam logic [2:0] CFG_ANG_SLEW  = 3'd5;
	localparam logic [2:0] CFG_BATT_THR  = 3'd6;

	// Register reset values
	localparam logic [7:0]  RST_LIN_STEP  = 8'd10;
	localparam logic [7:0]  RST_ANG_STEP  = 8'd10;
	localparam logic [10:0] RST_LIN_LIMIT = 11'd220;
	localparam logic [10:0] RST_ANG_LIMIT = 11'd284;
	localparam logic [7:0]  RST_LIN_SLEW  = 8'd5;
	localparam logic [7:0]  RST_ANG_SLEW  = 8'd5;
	localparam logic [6:0]  RST_BATT_THR  = 7'd15;

	// One command
	typedef struct packed {
		logic [2:0] action;
		logic [6:0] battery_percent;
	} cmd_item_t;

	// One result
	typedef struct packed {
		logic signed [11:0] linear_command;
		logic signed [11:0] angular_command;
		logic signed [11:0] linear_target;
		logic signed [11:0] angular_target;
		logic               battery_low;
		logic               halted;
	} res_item_t;

	// Per-axis command decode
	typedef struct packed {
		logic up;
		logic down;
		logic zero;
	} axis_ctrl_t;

endpackage

@@ hdl/vcr_axis.sv @@
// One axis: target step and clamp, then output slew toward the target.
`timescale 1ns / 1ps

module vcr_axis (
	input  vcr_pkg::axis_ctrl_t ctrl,
	input  logic signed [11:0]  target,
	input  logic signed [11:0]  velocity,
	input  logic [7:0]          step,
	input  logic [10:0]         limit,
	input  logic [7:0]          slew,
	output logic signed [11:0]  target_next,
	output logic signed [11:0]  velocity_next
);

	logic signed [13:0] tgt_ext;
	logic signed [13:0] step_ext;
	logic signed [13:0] lim_ext;
	logic signed [13:0] raw;
	logic signed [13:0] tgt_new;
	logic signed [13:0] vel_ext;
	logic signed [13:0] slew_ext;
	logic signed [13:0] vel_up;
	logic signed [13:0] vel_dn;
	logic signed [13:0] vel_new;

	// Target: add or subtract the step, clamp only when it moved
	always_comb begin
		tgt_ext  = 14'(target);
		step_ext = $signed({6'd0, step});
		lim_ext  = $signed({3'd0, limit});
		raw      = ctrl.up ? (tgt_ext + step_ext) : (tgt_ext - step_ext);
		if (ctrl.zero) begin
			tgt_new = '0;
		end else if (ctrl.up || ctrl.down) begin
			if (raw < -lim_ext) begin
				tgt_new = -lim_ext;
			end else if (raw > lim_ext) begin
				tgt_new = lim_ext;
			end else begin
				tgt_new = raw;
			end
		end else begin
			tgt_new = tgt_ext;
		end
	end

	// Output: move toward the target by at most the slew amount
	always_comb begin
		vel_ext  = ctrl.zero ? 14'sd0 : 14'(velocity);
		slew_ext = $signed({6'd0, slew});
		vel_up   = vel_ext + slew_ext;
		vel_dn   = vel_ext - slew_ext;
		if (tgt_new > vel_ext) begin
			vel_new = (vel_up < tgt_new) ? vel_up : tgt_new;
		end else if (tgt_new < vel_ext) begin
			vel_new = (vel_dn > tgt_new) ? vel_dn : tgt_new;
		end else begin
			vel_new = tgt_new;
		end
	end

	assign target_next   = tgt_new[11:0];
	assign velocity_next = vel_new[11:0];

endmodule

@@ hdl/velocity_command_ramp.sv @@
// Top level of the two-axis velocity command ramp.
`timescale 1ns / 1ps

// Velocity command ramp: turns teleop commands into slew-limited drive velocities.
//
// Command channel (cmd_valid / cmd_stall / cmd): one command per transfer, carrying
// the action code and the latest battery percent. Result channel (res_valid /
// res_stall / res): exactly one result per command, in order, with both slewed
// velocities, both targets, the low-battery flag and the halted flag.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; indexes beyond the register list are ignored. Write only while idle.
//
// Flow: a command taken at one edge sits in the command register, and its
// result is loaded into the result register once that register is empty or
// its result is taken, which raises res_valid. Throughput is one command per
// cycle while the result side does not stall; the target and velocity state
// updates at the same edge as a command leaves the command register, so the
// next command sees it immediately.
// When the receiver stalls, the result holds, the command register holds
// behind it, and cmd_stall rises only once both are full.
// Reset clears targets and velocities to zero, empties both registers and
// loads the register defaults.

module velocity_command_ramp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  vcr_pkg::cmd_item_t    cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output vcr_pkg::res_item_t    res,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [10:0]           cfg_data
);

	logic [7:0]  lin_step_q;
	logic [7:0]  ang_step_q;
	logic [10:0] lin_limit_q;
	logic [10:0] ang_limit_q;
	logic [7:0]  lin_slew_q;
	logic [7:0]  ang_slew_q;
	logic [6:0]  batt_thr_q;

	logic signed [11:0] tgt_lin_q;
	logic signed [11:0] tgt_ang_q;
	logic signed [11:0] vel_lin_q;
	logic signed [11:0] vel_ang_q;

	logic                valid_s1;
	vcr_pkg::cmd_item_t  cmd_s1;
	logic                res_valid_q;
	vcr_pkg::res_item_t  res_q;

	logic                advance;
	logic                take;
	vcr_pkg::axis_ctrl_t lin_ctrl;
	vcr_pkg::axis_ctrl_t ang_ctrl;
	logic                quit;
	logic signed [11:0]  tgt_lin_d;
	logic signed [11:0]  tgt_ang_d;
	logic signed [11:0]  vel_lin_d;
	logic signed [11:0]  vel_ang_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_step_q  <= vcr_pkg::RST_LIN_STEP;
			ang_step_q  <= vcr_pkg::RST_ANG_STEP;
			lin_limit_q <= vcr_pkg::RST_LIN_LIMIT;
			ang_limit_q <= vcr_pkg::RST_ANG_LIMIT;
			lin_slew_q  <= vcr_pkg::RST_LIN_SLEW;
			ang_slew_q  <= vcr_pkg::RST_ANG_SLEW;
			batt_thr_q  <= vcr_pkg::RST_BATT_THR;
		end else if (cfg_we) begin
			case (cfg_index)
				vcr_pkg::CFG_LIN_STEP:  lin_step_q  <= cfg_data[7:0];
				vcr_pkg::CFG_ANG_STEP:  ang_step_q  <= cfg_data[7:0];
				vcr_pkg::CFG_LIN_LIMIT: lin_limit_q <= cfg_data;
				vcr_pkg::CFG_ANG_LIMIT: ang_limit_q <= cfg_data;
				vcr_pkg::CFG_LIN_SLEW:  lin_slew_q  <= cfg_data[7:0];
				vcr_pkg::CFG_ANG_SLEW:  ang_slew_q  <= cfg_data[7:0];
				vcr_pkg::CFG_BATT_THR:  batt_thr_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Flow control: the result register frees up when empty or taken
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign take      = cmd_valid && !cmd_stall;

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	// Action decode
	always_comb begin
		lin_ctrl = '0;
		ang_ctrl = '0;
		quit     = 1'b0;
		case (cmd_s1.action)
			vcr_pkg::ACT_LIN_UP:   lin_ctrl.up   = 1'b1;
			vcr_pkg::ACT_LIN_DOWN: lin_ctrl.down = 1'b1;
			vcr_pkg::ACT_ANG_UP:   ang_ctrl.up   = 1'b1;
			vcr_pkg::ACT_ANG_DOWN: ang_ctrl.down = 1'b1;
			vcr_pkg::ACT_STOP: begin
				lin_ctrl.zero = 1'b1;
				ang_ctrl.zero = 1'b1;
			end
			vcr_pkg::ACT_QUIT: begin
				lin_ctrl.zero = 1'b1;
				ang_ctrl.zero = 1'b1;
				quit          = 1'b1;
			end
			default: ;
		endcase
	end

	vcr_axis u_lin (
		.ctrl          (lin_ctrl),
		.target        (tgt_lin_q),
		.velocity      (vel_lin_q),
		.step          (lin_step_q),
		.limit         (lin_limit_q),
		.slew          (lin_slew_q),
		.target_next   (tgt_lin_d),
		.velocity_next (vel_lin_d)
	);

	vcr_axis u_ang (
		.ctrl          (ang_ctrl),
		.target        (tgt_ang_q),
		.velocity      (vel_ang_q),
		.step          (ang_step_q),
		.limit         (ang_limit_q),
		.slew          (ang_slew_q),
		.target_next   (tgt_ang_d),
		.velocity_next (vel_ang_d)
	);

	// Axis state, updated as each command moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_lin_q <= '0;
			tgt_ang_q <= '0;
			vel_lin_q <= '0;
			vel_ang_q <= '0;
		end else if (advance) begin
			tgt_lin_q <= tgt_lin_d;
			tgt_ang_q <= tgt_ang_d;
			vel_lin_q <= vel_lin_d;
			vel_ang_q <= vel_ang_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.linear_command  <= vel_lin_d;
			res_q.angular_command <= vel_ang_d;
			res_q.linear_target   <= tgt_lin_d;
			res_q.angular_target  <= tgt_ang_d;
			res_q.battery_low     <= (cmd_s1.battery_percent < batt_thr_q);
			res_q.halted          <= quit;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ hdl/vcr_checker.sv @@
// Port-level checks for the velocity command ramp, bound to the top level.
`timescale 1ns / 1ps

module vcr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_stall,
	input logic                res_valid,
	input logic                res_stall,
	input vcr_pkg::res_item_t  res
);

	// A pending result is not withdrawn while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result changed while stalled");

	// Commands back up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command stalled with result side free");

	// A quit result carries zero velocities and targets
	a_quit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.halted |-> res.linear_command == 12'sd0 &&
			res.angular_command == 12'sd0 && res.linear_target == 12'sd0 &&
			res.angular_target == 12'sd0)
		else $error("quit result not zero");

endmodule

bind velocity_command_ramp vcr_checker u_vcr_checker (.*);

@@ tb/sv/tb_velocity_command_ramp.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the velocity command ramp: directed commands, then random phases.

module tb_velocity_command_ramp;

	// Codes with no package name: action 7 behaves as hold, register 7 does not exist
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	localparam int IDLE_LIMIT    = 1000;
	localparam int PHASES        = 10;
	localparam int PHASE_CMDS    = 155;
	localparam int BURST_CMDS    = 25;
	localparam int HOLD_OFF      = 48;
	localparam int DRAIN_CYCLES  = 6;
	localparam int PRESSURE_PHASE = 4;

	// One row of the directed table: command, and a hand-written result where it is obvious
	typedef struct packed {
		vcr_pkg::cmd_item_t  item;
		logic                typed;
		vcr_pkg::res_item_t  want;
	} cmd_row_t;

	localparam logic               TYPED     = 1'b1;
	localparam logic               PREDICTED = 1'b0;
	localparam vcr_pkg::res_item_t NO_WANT   = '0;
	localparam logic [47:0]        ZERO_AXES = '0;

	localparam int DIRECTED_ROWS = 18;
	localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
		{vcr_pkg::ACT_HOLD,     7'd0,   TYPED, ZERO_AXES, 1'b1, 1'b0},
		{vcr_pkg::ACT_HOLD,     7'd127, TYPED, ZERO_AXES, 1'b0, 1'b0},
		{vcr_pkg::ACT_LIN_UP,   7'd50,  TYPED, 12'sd5, 12'sd0, 12'sd10, 12'sd0, 1'b0, 1'b0},
		{vcr_pkg::ACT_LIN_UP,   7'd14,  PREDICTED, NO_WANT},
		{vcr_pkg::ACT_ANG_UP,   7'd15,  PREDICTED, NO_WANT},
		{vcr_pkg::ACT_ANG_DOWN, 7'd100, PREDICTED, NO_WANT},
		{vcr_pkg::ACT_ANG_DOWN, 7'd1,   PREDICTED, NO_WANT},
		{vcr_pkg::ACT_LIN_DOWN, 7'd60,  PREDICTED, NO_WANT},
		{ACT_UNUSED,            7'd64,  PREDICTED, NO_WANT},
		{vcr_pkg::ACT_STOP,     7'd42,  TYPED, ZERO_AXES, 1'b0, 1'b0},
		{vcr_pkg::ACT_LIN_DOWN, 7'd85,  PREDICTED, NO_WANT},
		{vcr_pkg::ACT_ANG_UP,   7'd7,   PREDICTED, NO_WANT},
		{vcr_pkg::ACT_QUIT,     7'd3,   TYPED, ZERO_AXES, 1'b1, 1'b1},
		{vcr_pkg::ACT_HOLD,     7'd85,  TYPED, ZERO_AXES, 1'b0, 1'b0},
		{vcr_pkg::ACT_LIN_UP,   7'd42,  PREDICTED, NO_WANT},
		{vcr_pkg::ACT_ANG_DOWN, 7'd127, PREDICTED, NO_WANT},
		{ACT_UNUSED,            7'd0,   PREDICTED, NO_WANT},
		{vcr_pkg::ACT_QUIT,     7'd127, TYPED, ZERO_AXES, 1'b0, 1'b1}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	vcr_pkg::cmd_item_t  cmd;
	logic                res_valid;
	logic                res_stall;
	vcr_pkg::res_item_t  res;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [10:0]         cfg_data;

	// Shadow copy of the registers and the ramp state
	logic [7:0]  lin_step, ang_step, lin_slew, ang_slew;
	logic [10:0] lin_limit, ang_limit;
	logic [6:0]  batt_thr;
	int          tgt_lin, tgt_ang, vel_lin, vel_ang;

	vcr_pkg::res_item_t  pending_results[$];
	vcr_pkg::res_item_t  oldest;
	int          fails;
	int          n_cmds;
	int          n_results;
	int          n_quits;
	int          idle_cycles;
	bit          hold_off_req;

	velocity_command_ramp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register writes land in the shadow copy, masked to each register's width
	function automatic void mirror_write(logic [2:0] idx, logic [10:0] data);
		case (idx)
			vcr_pkg::CFG_LIN_STEP:  lin_step  = data[7:0];
			vcr_pkg::CFG_ANG_STEP:  ang_step  = data[7:0];
			vcr_pkg::CFG_LIN_LIMIT: lin_limit = data;
			vcr_pkg::CFG_ANG_LIMIT: ang_limit = data;
			vcr_pkg::CFG_LIN_SLEW:  lin_slew  = data[7:0];
			vcr_pkg::CFG_ANG_SLEW:  ang_slew  = data[7:0];
			vcr_pkg::CFG_BATT_THR:  batt_thr  = data[6:0];
			default: ;
		endcase
	endfunction

	function automatic int clamp_target(int v, int lim);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Move a velocity toward its target by at most rate
	function automatic int approach(int cur, int goal, int rate);
		if (goal > cur)
			return (cur + rate < goal) ? cur + rate : goal;
		if (goal < cur)
			return (cur - rate > goal) ? cur - rate : goal;
		return goal;
	endfunction

	// Advance the shadow state by one command and build the result it produces
	function automatic vcr_pkg::res_item_t ramp_step(vcr_pkg::cmd_item_t c);
		vcr_pkg::res_item_t r;
		logic      quit;
		quit = 1'b0;
		case (c.action)
			vcr_pkg::ACT_LIN_UP:
				tgt_lin = clamp_target(tgt_lin + int'(lin_step), int'(lin_limit));
			vcr_pkg::ACT_LIN_DOWN:
				tgt_lin = clamp_target(tgt_lin - int'(lin_step), int'(lin_limit));
			vcr_pkg::ACT_ANG_UP:
				tgt_ang = clamp_target(tgt_ang + int'(ang_step), int'(ang_limit));
			vcr_pkg::ACT_ANG_DOWN:
				tgt_ang = clamp_target(tgt_ang - int'(ang_step), int'(ang_limit));
			vcr_pkg::ACT_STOP, vcr_pkg::ACT_QUIT: begin
				tgt_lin = 0;
				tgt_ang = 0;
				vel_lin = 0;
				vel_ang = 0;
				quit = (c.action == vcr_pkg::ACT_QUIT);
			end
			default: ;
		endcase
		vel_lin = approach(vel_lin, tgt_lin, int'(lin_slew));
		vel_ang = approach(vel_ang, tgt_ang, int'(ang_slew));
		r.linear_command  = vel_lin[11:0];
		r.angular_command = vel_ang[11:0];
		r.linear_target   = tgt_lin[11:0];
		r.angular_target  = tgt_ang[11:0];
		r.battery_low     = (c.battery_percent < batt_thr);
		r.halted          = quit;
		return r;
	endfunction

	// Offer one command after a gap; called and returning at a falling edge
	task automatic send_cmd(vcr_pkg::cmd_item_t c, int gap, logic typed,
		vcr_pkg::res_item_t want);
		vcr_pkg::res_item_t r;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		r = ramp_step(c);
		if (r.halted)
			n_quits++;
		pending_results.push_back(typed ? want : r);
		n_cmds++;
		@(negedge clk);
	endtask

	// One register write; the caller lowers the write enable after the last one
	task automatic cfg_write(logic [2:0] idx, logic [10:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		mirror_write(idx, data);
		@(negedge clk);
	endtask

	// Wait until every expected result has come back, then let the pipeline settle
	task automatic drain();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Result side: random stall before each transfer, with calm stretches and one long hold-off
	initial begin
		int wait_n;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				wait_n = HOLD_OFF;
				hold_off_req = 1'b0;
			end else if ((n_results / 40) % 3 == 0)
				wait_n = 0;
			else
				wait_n = $urandom_range(0, 6);
			if (wait_n > 0) begin
				res_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				fails++;
			end else begin
				oldest = pending_results.pop_front();
				if (res.linear_command !== oldest.linear_command) begin
					$error("linear_command: expected %0d, got %0d",
						oldest.linear_command, res.linear_command);
					fails++;
				end
				if (res.angular_command !== oldest.angular_command) begin
					$error("angular_command: expected %0d, got %0d",
						oldest.angular_command, res.angular_command);
					fails++;
				end
				if (res.linear_target !== oldest.linear_target) begin
					$error("linear_target: expected %0d, got %0d",
						oldest.linear_target, res.linear_target);
					fails++;
				end
				if (res.angular_target !== oldest.angular_target) begin
					$error("angular_target: expected %0d, got %0d",
						oldest.angular_target, res.angular_target);
					fails++;
				end
				if (res.battery_low !== oldest.battery_low) begin
					$error("battery_low: expected %0d, got %0d",
						oldest.battery_low, res.battery_low);
					fails++;
				end
				if (res.halted !== oldest.halted) begin
					$error("halted: expected %0d, got %0d", oldest.halted, res.halted);
					fails++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("velocity_command_ramp regression: fail");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, then random phases under several settings
	initial begin
		vcr_pkg::cmd_item_t c;
		logic [2:0]  favored;
		logic [10:0] step_l, step_a, lim_l, lim_a, slew_l, slew_a, thr;
		bit          calm;
		int          pick;

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = vcr_pkg::CFG_LIN_STEP;
		cfg_data = '0;
		hold_off_req = 1'b0;
		fails = 0;
		n_cmds = 0;
		n_results = 0;
		n_quits = 0;
		idle_cycles = 0;
		lin_step = vcr_pkg::RST_LIN_STEP;
		ang_step = vcr_pkg::RST_ANG_STEP;
		lin_limit = vcr_pkg::RST_LIN_LIMIT;
		ang_limit = vcr_pkg::RST_ANG_LIMIT;
		lin_slew = vcr_pkg::RST_LIN_SLEW;
		ang_slew = vcr_pkg::RST_ANG_SLEW;
		batt_thr = vcr_pkg::RST_BATT_THR;
		tgt_lin = 0;
		tgt_ang = 0;
		vel_lin = 0;
		vel_ang = 0;
		favored = vcr_pkg::ACT_LIN_UP;
		calm = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands with the reset register values
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_cmd(DIRECTED[i].item, $urandom_range(0, 2), DIRECTED[i].typed,
				DIRECTED[i].want);
		cmd_valid <= 1'b0;
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			// Pick a setting; targets carry over, so a shrunken limit leaves held targets alone
			case (phase)
				1: begin
					step_l = '1; step_a = '1; lim_l = '1; lim_a = '1;
					slew_l = '1; slew_a = '1; thr = '1;
				end
				2: begin
					step_l = 11'd255; step_a = 11'd255;
					lim_l = 11'($urandom_range(1, 120));
					lim_a = 11'($urandom_range(1, 120));
					slew_l = 11'd1; slew_a = 11'd1; thr = 11'd100;
				end
				3: begin
					step_l = '0; step_a = '0; lim_l = '0; lim_a = '0;
					slew_l = '0; slew_a = '0; thr = '0;
				end
				PRESSURE_PHASE: begin
					step_l = 11'(vcr_pkg::RST_LIN_STEP);
					step_a = 11'(vcr_pkg::RST_ANG_STEP);
					lim_l = vcr_pkg::RST_LIN_LIMIT;
					lim_a = vcr_pkg::RST_ANG_LIMIT;
					slew_l = 11'(vcr_pkg::RST_LIN_SLEW);
					slew_a = 11'(vcr_pkg::RST_ANG_SLEW);
					thr = 11'(vcr_pkg::RST_BATT_THR);
				end
				default: begin
					// Upper bits of the data are random too and must be masked off
					step_l = 11'($urandom_range(0, 2047));
					step_a = 11'($urandom_range(0, 2047));
					lim_l = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
						: 11'($urandom_range(0, 300));
					lim_a = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
						: 11'($urandom_range(0, 300));
					slew_l = 11'($urandom_range(0, 2047));
					slew_a = 11'($urandom_range(0, 2047));
					thr = 11'($urandom_range(0, 2047));
				end
			endcase
			cfg_write(vcr_pkg::CFG_LIN_STEP, step_l);
			cfg_write(vcr_pkg::CFG_ANG_STEP, step_a);
			cfg_write(vcr_pkg::CFG_LIN_LIMIT, lim_l);
			cfg_write(vcr_pkg::CFG_ANG_LIMIT, lim_a);
			cfg_write(vcr_pkg::CFG_LIN_SLEW, slew_l);
			cfg_write(vcr_pkg::CFG_ANG_SLEW, slew_a);
			cfg_write(vcr_pkg::CFG_BATT_THR, thr);
			cfg_write(CFG_UNUSED, 11'($urandom_range(0, 2047)));
			cfg_we <= 1'b0;
			@(negedge clk);

			if (phase == PRESSURE_PHASE)
				hold_off_req = 1'b1;

			for (int k = 0; k < PHASE_CMDS; k++) begin
				// Each burst leans on one direction so targets run into their clamps
				if (k % BURST_CMDS == 0) begin
					favored = 3'($urandom_range(vcr_pkg::ACT_LIN_UP, vcr_pkg::ACT_ANG_DOWN));
					calm = (phase == PRESSURE_PHASE && k == 0) || ($urandom_range(0, 2) == 0);
				end
				pick = $urandom_range(0, 99);
				if (pick < 45)
					c.action = favored;
				else if (pick < 55)
					c.action = vcr_pkg::ACT_HOLD;
				else if (pick < 58)
					c.action = ACT_UNUSED;
				else if (pick < 61)
					c.action = vcr_pkg::ACT_STOP;
				else if (pick < 63)
					c.action = vcr_pkg::ACT_QUIT;
				else
					c.action = 3'($urandom_range(vcr_pkg::ACT_LIN_UP, vcr_pkg::ACT_ANG_DOWN));
				c.battery_percent = 7'($urandom_range(0, 127));
				send_cmd(c, calm ? 0 : $urandom_range(0, 6), PREDICTED, NO_WANT);
			end
			cmd_valid <= 1'b0;
			drain();
		end

		$display("covered %0d commands and %0d results, %0d of them quits,",
			n_cmds, n_results, n_quits);
		$display("over %0d register settings including all-zero and all-ones", PHASES + 1);
		if (fails == 0)
			$display("velocity_command_ramp regression: pass");
		else
			$display("velocity_command_ramp regression: fail");
		$finish;
	end

endmodule
